// ===== hw/rtl/mfqs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mfqs_pkg;

    localparam int CMD_W     = 3;
    localparam int TID_W     = 4;
    localparam int LVL_OUT_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_NEW     = 3'd0,
        CMD_BLOCK   = 3'd1,
        CMD_END     = 3'd2,
        CMD_TIMER   = 3'd3,
        CMD_UNBLOCK = 3'd4
    } t_cmd;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/multilevel_feedback_queue_scheduler_top.sv =====
// Multilevel feedback queue scheduler. One event (new, block, end, timer tick,
// unblock) is taken when start is high and busy is low; busy then stays high
// for one cycle while the event executes, and the result word is shown for
// exactly one cycle with o_done high in the cycle after that. The execute
// cycle is needed for the read latency of the queue entry memory and the
// per-thread level memory, which are both read at the accept edge and updated
// at the end of the execute cycle. The receiver cannot stall: every result
// must be taken in the cycle that o_done marks. No clearing pass is needed
// after reset; the block is ready in the first cycle out of reset.
`timescale 1ns / 1ps
`default_nettype none

module multilevel_feedback_queue_scheduler_top #(
    parameter int MAX_THREADS = 16,
    parameter int LEVELS      = 5
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire  [mfqs_pkg::CMD_W-1:0]   i_command,
    input  wire  [mfqs_pkg::TID_W-1:0]   i_thread_id,
    output logic                         o_done,
    output logic                         o_switched,
    output logic [mfqs_pkg::TID_W-1:0]   o_old_thread,
    output logic [mfqs_pkg::TID_W-1:0]   o_next_thread,
    output logic [mfqs_pkg::LVL_OUT_W-1:0] o_next_level,
    output logic                         o_none_ready,
    output logic                         o_queue_overflow
);

    import mfqs_pkg::*;

    localparam int TW    = $clog2(MAX_THREADS);
    localparam int PW    = $clog2(MAX_THREADS);
    localparam int CW    = $clog2(MAX_THREADS + 1);
    localparam int LW    = $clog2(LEVELS);
    localparam int DEPTH = LEVELS * MAX_THREADS;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic [AW-1:0] f_addr(input logic [LW-1:0] lv, input logic [PW-1:0] p);
        logic [AW-1:0] base;
        base = AW'(AW'(lv) * AW'(MAX_THREADS));
        return base + AW'(p);
    endfunction

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        if (32'(p) == MAX_THREADS - 1) begin
            q = '0;
        end else begin
            q = p + PW'(1);
        end
        return q;
    endfunction

    // memories
    logic [TID_W-1:0] r_store [DEPTH];
    logic [LW-1:0]    r_level_mem [MAX_THREADS];
    logic [MAX_THREADS-1:0] r_level_vld;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [TID_W-1:0] r_tid;
    logic [TID_W-1:0] r_running;
    logic [TID_W-1:0] r_store_rd;
    logic [LW-1:0]    r_level_rd;
    logic             r_level_rd_vld;

    logic [PW-1:0] r_head  [LEVELS];
    logic [PW-1:0] r_tail  [LEVELS];
    logic [CW-1:0] r_count [LEVELS];

    logic                   r_done;
    logic                   r_switched;
    logic [TID_W-1:0]       r_old_thread;
    logic [TID_W-1:0]       r_next_thread;
    logic [LVL_OUT_W-1:0]   r_next_level;
    logic                   r_none_ready;
    logic                   r_overflow;

    logic              accept;
    logic [LEVELS-1:0] nz;
    logic [LEVELS-1:0] full;
    logic [LW-1:0]     dsp_lvl;
    logic              dsp_any;
    logic [TID_W-1:0]  lvl_rd_tid;

    logic [LW-1:0]    lv_cur;
    logic             tid_ok;
    logic             run_ok;
    logic             push_en;
    logic             push_ok;
    logic             overflow;
    logic [LW-1:0]    push_lv;
    logic [TID_W-1:0] push_tid;
    logic             lvl_we;
    logic [TID_W-1:0] lvl_wtid;
    logic [LW-1:0]    lvl_wdata;
    logic             dispatch;
    logic             pop;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        busy    = 1'b0;
        accept  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                accept = start;
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                busy    = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // occupancy and lowest-numbered (highest priority) non-empty level
    always_comb begin
        dsp_lvl = '0;
        dsp_any = 1'b0;
        for (int l = 0; l < LEVELS; l++) begin
            nz[l]   = (r_count[l] != '0);
            full[l] = (r_count[l] == CW'(MAX_THREADS));
        end
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (nz[l]) begin
                dsp_lvl = LW'(l);
                dsp_any = 1'b1;
            end
        end
    end

    assign lvl_rd_tid = (i_command == CMD_TIMER) ? r_running : i_thread_id;

    // accept edge: latch the event and start both memory reads
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd          <= t_cmd'(i_command);
            r_tid          <= i_thread_id;
            r_store_rd     <= r_store[f_addr(dsp_lvl, r_head[dsp_lvl])];
            r_level_rd     <= r_level_mem[TW'(lvl_rd_tid)];
            r_level_rd_vld <= r_level_vld[TW'(lvl_rd_tid)];
        end
    end

    // execute cycle decode
    always_comb begin
        lv_cur    = r_level_rd_vld ? r_level_rd : '0;
        tid_ok    = (32'(r_tid) < MAX_THREADS);
        run_ok    = (32'(r_running) < MAX_THREADS);
        push_en   = 1'b0;
        push_lv   = '0;
        push_tid  = r_tid;
        lvl_we    = 1'b0;
        lvl_wtid  = r_tid;
        lvl_wdata = '0;
        dispatch  = 1'b0;
        unique case (r_cmd) inside
            CMD_NEW: begin
                if (tid_ok) begin
                    push_en = 1'b1;
                    lvl_we  = 1'b1;
                end
            end
            CMD_BLOCK, CMD_END: begin
                dispatch = 1'b1;
            end
            CMD_TIMER: begin
                if (run_ok && (32'(lv_cur) < LEVELS - 1) && nz[lv_cur]) begin
                    push_en   = 1'b1;
                    push_lv   = lv_cur + LW'(1);
                    push_tid  = r_running;
                    lvl_we    = 1'b1;
                    lvl_wtid  = r_running;
                    lvl_wdata = lv_cur + LW'(1);
                    dispatch  = 1'b1;
                end
            end
            CMD_UNBLOCK: begin
                if (tid_ok) begin
                    push_en = 1'b1;
                    push_lv = lv_cur;
                end
            end
            default: begin
            end
        endcase
        overflow = push_en && full[push_lv];
        push_ok  = push_en && !full[push_lv];
        pop      = (r_state == S_EXEC) && dispatch && dsp_any;
    end

    // write back
    always_ff @(posedge i_clk) begin
        if ((r_state == S_EXEC) && push_ok) begin
            r_store[f_addr(push_lv, r_tail[push_lv])] <= push_tid;
        end
        if ((r_state == S_EXEC) && lvl_we) begin
            r_level_mem[TW'(lvl_wtid)] <= lvl_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_vld <= '0;
            r_running   <= '0;
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
        end else if (r_state == S_EXEC) begin
            if (lvl_we) begin
                r_level_vld[TW'(lvl_wtid)] <= 1'b1;
            end
            if (pop) begin
                r_running <= r_store_rd;
            end
            for (int l = 0; l < LEVELS; l++) begin
                if (push_ok && (push_lv == LW'(l))) begin
                    r_tail[l] <= f_inc(r_tail[l]);
                end
                if (pop && (dsp_lvl == LW'(l))) begin
                    r_head[l] <= f_inc(r_head[l]);
                end
                r_count[l] <= r_count[l]
                            + CW'(push_ok && (push_lv == LW'(l)))
                            - CW'(pop && (dsp_lvl == LW'(l)));
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == S_EXEC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            r_switched    <= dispatch;
            r_old_thread  <= dispatch ? r_running : '0;
            r_next_thread <= pop ? r_store_rd : '0;
            r_next_level  <= pop ? LVL_OUT_W'(dsp_lvl) : '0;
            r_none_ready  <= dispatch && !dsp_any;
            r_overflow    <= overflow;
        end
    end

    assign o_done           = r_done;
    assign o_switched       = r_switched;
    assign o_old_thread     = r_old_thread;
    assign o_next_thread    = r_next_thread;
    assign o_next_level     = r_next_level;
    assign o_none_ready     = r_none_ready;
    assign o_queue_overflow = r_overflow;

    a_exec_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy ##1 (!busy && o_done)))
        else $error("event did not finish in two cycles");

    a_done_only_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_EXEC))
        else $error("result strobe without an executed event");

    a_running_follows_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_switched && !o_none_ready) |-> (r_running == o_next_thread))
        else $error("running thread does not match dispatched thread");

    a_quiet_without_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_switched) |-> (o_old_thread == '0 && o_next_thread == '0
                                     && o_next_level == '0 && !o_none_ready))
        else $error("dispatch fields set without a switch");

    a_none_ready_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_none_ready) |-> (o_next_thread == '0 && o_next_level == '0
                                      && o_switched))
        else $error("empty dispatch reports a thread");

endmodule

`default_nettype wire

// ===== dv/multilevel_feedback_queue_scheduler_top_tb.sv =====
`timescale 1ns / 1ps

module multilevel_feedback_queue_scheduler_top_tb;
    import mfqs_pkg::*;

    localparam int MAX_THREADS    = 16;
    localparam int LEVELS         = 5;
    localparam int CLK_HALF       = 6;
    localparam int WATCHDOG_LIMIT = 300;
    localparam int RANDOM_EVENTS  = 300;
    localparam logic [CMD_W-1:0] CMD_RSVD_LO  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_MID = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI  = 3'd7;

    typedef struct packed {
        logic                 switched;
        logic [TID_W-1:0]     old_thread;
        logic [TID_W-1:0]     next_thread;
        logic [LVL_OUT_W-1:0] next_level;
        logic                 none_ready;
        logic                 queue_overflow;
    } t_sched_word;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [CMD_W-1:0]     i_command;
    logic [TID_W-1:0]     i_thread_id;
    logic                 o_done;
    logic                 o_switched;
    logic [TID_W-1:0]     o_old_thread;
    logic [TID_W-1:0]     o_next_thread;
    logic [LVL_OUT_W-1:0] o_next_level;
    logic                 o_none_ready;
    logic                 o_queue_overflow;

    // scheduler state mirror
    logic [TID_W-1:0]     rq_store [LEVELS][MAX_THREADS];
    logic [TID_W-1:0]     rq_head  [LEVELS];
    logic [TID_W-1:0]     rq_tail  [LEVELS];
    int                   rq_count [LEVELS];
    logic [LVL_OUT_W-1:0] thr_level [MAX_THREADS];
    logic [TID_W-1:0]     cur_thread;

    t_sched_word pending_words [$];
    bit          no_idle;
    int          fail_count;
    int          idle_cycles;
    int          cmd_hist [8];
    int          n_switch;
    int          n_none;
    int          n_overflow;
    int          n_checked;

    multilevel_feedback_queue_scheduler_top #(
        .MAX_THREADS (MAX_THREADS),
        .LEVELS      (LEVELS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_thread_id      (i_thread_id),
        .o_done           (o_done),
        .o_switched       (o_switched),
        .o_old_thread     (o_old_thread),
        .o_next_thread    (o_next_thread),
        .o_next_level     (o_next_level),
        .o_none_ready     (o_none_ready),
        .o_queue_overflow (o_queue_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    function automatic bit ready_push(input int lvl, input logic [TID_W-1:0] tid);
        if (rq_count[lvl] >= MAX_THREADS) return 1'b0;
        rq_store[lvl][rq_tail[lvl]] = tid;
        rq_tail[lvl]++;
        rq_count[lvl]++;
        return 1'b1;
    endfunction

    function automatic t_sched_word schedule_event(input logic [CMD_W-1:0] cmd,
                                                   input logic [TID_W-1:0] tid);
        t_sched_word          w;
        logic                 dispatch;
        logic [LVL_OUT_W-1:0] lv;
        w = '0;
        dispatch = 1'b0;
        case (cmd)
            CMD_NEW: begin
                thr_level[tid] = '0;
                w.queue_overflow = !ready_push(0, tid);
            end
            CMD_BLOCK, CMD_END: dispatch = 1'b1;
            CMD_TIMER: begin
                lv = thr_level[cur_thread];
                if (lv < LEVELS - 1 && rq_count[lv] != 0) begin
                    lv++;
                    thr_level[cur_thread] = lv;
                    w.queue_overflow = !ready_push(lv, cur_thread);
                    dispatch = 1'b1;
                end
            end
            CMD_UNBLOCK: w.queue_overflow = !ready_push(thr_level[tid], tid);
            default: ;
        endcase
        if (dispatch) begin
            w.switched   = 1'b1;
            w.old_thread = cur_thread;
            w.none_ready = 1'b1;
            for (int i = 0; i < LEVELS; i++) begin
                if (w.none_ready && rq_count[i] != 0) begin
                    w.next_thread = rq_store[i][rq_head[i]];
                    w.next_level  = LVL_OUT_W'(i);
                    w.none_ready  = 1'b0;
                    rq_head[i]++;
                    rq_count[i]--;
                    cur_thread = w.next_thread;
                end
            end
        end
        return w;
    endfunction

    task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [TID_W-1:0] tid);
        int          gap;
        t_sched_word w;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start       <= 1'b1;
        i_command   <= cmd;
        i_thread_id <= tid;
        do @(posedge i_clk); while (busy);
        w = schedule_event(cmd, tid);
        pending_words.push_back(w);
        cmd_hist[cmd]++;
        n_switch   += w.switched;
        n_none     += w.none_ready;
        n_overflow += w.queue_overflow;
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_sched_word w;
        if (i_rst_n && o_done) begin
            if (pending_words.size() == 0) begin
                $display("%0t: result word with none expected, expected none actual %0h",
                         $time, {o_switched, o_old_thread, o_next_thread, o_next_level,
                                 o_none_ready, o_queue_overflow});
                fail_count++;
            end else begin
                w = pending_words.pop_front();
                check_field("switched", w.switched, o_switched);
                check_field("old_thread", w.old_thread, o_old_thread);
                check_field("next_thread", w.next_thread, o_next_thread);
                check_field("next_level", w.next_level, o_next_level);
                check_field("none_ready", w.none_ready, o_none_ready);
                check_field("queue_overflow", w.queue_overflow, o_queue_overflow);
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d words outstanding", $time,
                     pending_words.size());
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_empty_dispatch();
        send_event(CMD_BLOCK, 4'd0);
        send_event(CMD_END, 4'd15);
        send_event(CMD_TIMER, 4'd9);
        send_event(CMD_RSVD_LO, 4'd15);
        send_event(CMD_RSVD_MID, 4'd5);
        send_event(CMD_RSVD_HI, 4'd10);
    endtask

    task automatic test_enqueue_dispatch();
        send_event(CMD_NEW, 4'd0);
        send_event(CMD_NEW, 4'd15);
        send_event(CMD_NEW, 4'd10);
        send_event(CMD_NEW, 4'd10);
        send_event(CMD_BLOCK, 4'd3);
        send_event(CMD_UNBLOCK, 4'd15);
        send_event(CMD_END, 4'd0);
        send_event(CMD_BLOCK, 4'd15);
    endtask

    task automatic test_demotion();
        send_event(CMD_NEW, 4'd1);
        send_event(CMD_NEW, 4'd2);
        repeat (6) send_event(CMD_TIMER, 4'd0);
        send_event(CMD_UNBLOCK, 4'd1);
        repeat (3) send_event(CMD_END, 4'd2);
        send_event(CMD_TIMER, 4'd7);
    endtask

    task automatic test_queue_full();
        logic [TID_W-1:0] tid;
        repeat (3) begin
            no_idle = ($urandom_range(0, 1) == 0);
            repeat ($urandom_range(16, 19)) send_event(CMD_NEW, 4'($urandom));
            repeat ($urandom_range(1, 3)) send_event(CMD_TIMER, 4'($urandom));
            tid = 4'($urandom);
            repeat ($urandom_range(16, 19)) send_event(CMD_UNBLOCK, tid);
            repeat ($urandom_range(30, 40)) begin
                send_event($urandom_range(0, 1) ? CMD_BLOCK : CMD_END, 4'($urandom));
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        int               sent;
        int               r;
        int               pool;
        logic [CMD_W-1:0] cmd;
        sent = 0;
        while (sent < RANDOM_EVENTS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            pool = $urandom_range(0, 1) ? 3 : 15;
            repeat ($urandom_range(10, 30)) begin
                r = $urandom_range(0, 99);
                if (r < 25)      cmd = CMD_NEW;
                else if (r < 40) cmd = CMD_UNBLOCK;
                else if (r < 65) cmd = CMD_TIMER;
                else if (r < 78) cmd = CMD_BLOCK;
                else if (r < 92) cmd = CMD_END;
                else             cmd = CMD_W'($urandom);
                send_event(cmd, 4'($urandom_range(0, pool)));
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_command   = '0;
        i_thread_id = '0;
        no_idle     = 1'b0;
        fail_count  = 0;
        idle_cycles = 0;
        n_switch    = 0;
        n_none      = 0;
        n_overflow  = 0;
        n_checked   = 0;
        cur_thread  = '0;
        foreach (cmd_hist[i]) cmd_hist[i] = 0;
        foreach (rq_count[i]) begin
            rq_count[i] = 0;
            rq_head[i]  = '0;
            rq_tail[i]  = '0;
        end
        foreach (thr_level[i]) thr_level[i] = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_dispatch();
        test_enqueue_dispatch();
        test_demotion();
        test_queue_full();
        test_random_traffic();

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d words checked: %0d new, %0d block, %0d end, %0d tick, %0d unblock",
                 n_checked, cmd_hist[CMD_NEW], cmd_hist[CMD_BLOCK], cmd_hist[CMD_END],
                 cmd_hist[CMD_TIMER], cmd_hist[CMD_UNBLOCK]);
        $display("%0d dispatches, %0d with nothing ready, %0d dropped on full queue",
                 n_switch, n_none, n_overflow);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
